@@ src/uart16550_pkg.sv @@
// ----------------------------------------------------------------------------
// uart16550_pkg: shared types and constants for the 16550 register block
// Holds the word types, the event and register offset codes, the register bit
// positions and the queue pointer helper.
// ----------------------------------------------------------------------------
`default_nettype none

package uart16550_pkg;

  // queue geometry
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  // event codes carried in func
  localparam logic [1:0] FUNC_READ    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_LINE_RX = 2'd2;
  localparam logic [1:0] FUNC_TX_SLOT = 2'd3;

  // register offsets
  localparam logic [2:0] REG_RHR_THR = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_ISR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  // register bit positions
  localparam int unsigned LCR_DLAB_BIT  = 7;
  localparam int unsigned LSR_DR_BIT    = 0;
  localparam int unsigned LSR_OE_BIT    = 1;
  localparam int unsigned LSR_THRE_BIT  = 5;
  localparam int unsigned LSR_TEMT_BIT  = 6;
  localparam int unsigned IER_RX_BIT    = 0;
  localparam int unsigned IER_THRE_BIT  = 1;
  localparam int unsigned FCR_EN_BIT    = 0;
  localparam int unsigned FCR_RXCLR_BIT = 1;
  localparam int unsigned FCR_TXCLR_BIT = 2;

  // interrupt identification codes
  localparam logic [7:0] ISR_FIFO_ON = 8'hC0;
  localparam logic [7:0] ISR_RX_DATA = 8'h04;
  localparam logic [7:0] ISR_THRE    = 8'h02;
  localparam logic [7:0] ISR_NONE    = 8'h01;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic [7:0] line_byte;
  } uart_in_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic [15:0] baud_divisor;
    logic [1:0]  word_length;
  } uart_out_t;

  // queue index base + offs, wrapped at the queue depth (offs never exceeds depth)
  function automatic ptr_t ptr_add(ptr_t base, cnt_t offs);
    sum_t sum;
    sum = sum_t'(base) + sum_t'(offs);
    if (sum >= sum_t'(FIFO_DEPTH)) begin
      sum = sum - sum_t'(FIFO_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/uart_16550_register_block.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_block: 16550-style UART register file and data queues
// Takes one event word per cycle unless the output stalls (bus read, bus write,
// received line byte or free transmit slot) and returns one result word per event.
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid_i / in_ready_o / in_data_i carries one event word
// - output channel out_valid_o / out_ready_i / out_data_o carries one result
//   word per event, in event order
// - an accepted word sits in the input register, then the register and queue
//   update runs in one combinational pass and writes the result register
// - throughput is one word per cycle while out_ready_i takes the results; the
//   figure is set by the single pass through the register and queue update logic
// - when the receiver stalls, the finished result holds in the output
//   register and one more word is held in the input register; in_ready_o
//   then drops until the result is taken
// - reset clears the valid flags and all state registers, counts and pointers, both queues read empty;
//   queue storage itself is not cleared (only written entries are ever read)
// - fifos off: each queue holds one byte; fifos on: FIFO_DEPTH bytes
// - a full receive queue drops the line byte and flags overrun in the LSR,
//   a full transmit queue drops the THR write
// ----------------------------------------------------------------------------
`default_nettype none

module uart_16550_register_block
  import uart16550_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire uart_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output uart_out_t      out_data_o
);

  // input register
  logic     in_valid_q;
  uart_in_t in_q;

  // output register
  logic      out_valid_q;
  uart_out_t out_q;

  // queue storage, no reset
  logic [7:0] rx_queue_q [FIFO_DEPTH];
  logic [7:0] tx_queue_q [FIFO_DEPTH];

  // architectural state
  ptr_t       rx_head_q, rx_head_d;
  cnt_t       rx_count_q, rx_count_d;
  ptr_t       tx_head_q, tx_head_d;
  cnt_t       tx_count_q, tx_count_d;
  logic [3:0] int_enable_q, int_enable_d;
  logic [7:0] line_control_q, line_control_d;
  logic [7:0] divisor_low_q, divisor_low_d;
  logic [7:0] divisor_high_q, divisor_high_d;
  logic       fifo_on_q, fifo_on_d;
  logic       thre_pending_q, thre_pending_d;
  logic       overrun_flag_q, overrun_flag_d;

  // queue write controls
  logic       rx_we, tx_we;
  ptr_t       rx_widx, tx_widx;

  logic       advance;
  logic       dlab;
  cnt_t       capacity;
  uart_out_t  res;

  // the item in the input register moves on when the output register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign dlab     = line_control_q[LCR_DLAB_BIT];
  assign capacity = fifo_on_q ? cnt_t'(FIFO_DEPTH) : cnt_t'(1);
  assign rx_widx  = ptr_add(rx_head_q, rx_count_q);
  assign tx_widx  = ptr_add(tx_head_q, tx_count_q);

  // single update pass for the item in the input register
  always_comb begin
    rx_head_d      = rx_head_q;
    rx_count_d     = rx_count_q;
    tx_head_d      = tx_head_q;
    tx_count_d     = tx_count_q;
    int_enable_d   = int_enable_q;
    line_control_d = line_control_q;
    divisor_low_d  = divisor_low_q;
    divisor_high_d = divisor_high_q;
    fifo_on_d      = fifo_on_q;
    thre_pending_d = thre_pending_q;
    overrun_flag_d = overrun_flag_q;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    res            = '0;

    case (in_q.func)
      FUNC_READ: begin
        case (in_q.addr)
          REG_RHR_THR: begin
            if (dlab) begin
              res.rdata = divisor_low_q;
            end else if (rx_count_q != '0) begin
              // pop the oldest received byte
              res.rdata  = rx_queue_q[rx_head_q];
              rx_head_d  = ptr_add(rx_head_q, cnt_t'(1));
              rx_count_d = rx_count_q - cnt_t'(1);
            end
          end
          REG_IER: begin
            res.rdata = dlab ? divisor_high_q : {4'b0, int_enable_q};
          end
          REG_ISR_FCR: begin
            if (int_enable_q[IER_RX_BIT] && rx_count_q != '0) begin
              res.rdata = ISR_RX_DATA;
            end else if (int_enable_q[IER_THRE_BIT] && thre_pending_q) begin
              // reporting thr empty acknowledges it
              res.rdata      = ISR_THRE;
              thre_pending_d = 1'b0;
            end else begin
              res.rdata = ISR_NONE;
            end
            if (fifo_on_q) begin
              res.rdata = res.rdata | ISR_FIFO_ON;
            end
          end
          REG_LCR: begin
            res.rdata = line_control_q;
          end
          REG_LSR: begin
            res.rdata[LSR_DR_BIT]   = (rx_count_q != '0);
            res.rdata[LSR_OE_BIT]   = overrun_flag_q;
            res.rdata[LSR_THRE_BIT] = (tx_count_q == '0);
            res.rdata[LSR_TEMT_BIT] = (tx_count_q == '0);
            overrun_flag_d          = 1'b0;
          end
          default: begin
          end
        endcase
      end

      FUNC_WRITE: begin
        case (in_q.addr)
          REG_RHR_THR: begin
            if (dlab) begin
              divisor_low_d = in_q.wdata;
            end else begin
              thre_pending_d = 1'b0;
              if (tx_count_q < capacity) begin
                tx_we      = 1'b1;
                tx_count_d = tx_count_q + cnt_t'(1);
              end
            end
          end
          REG_IER: begin
            if (dlab) begin
              divisor_high_d = in_q.wdata;
            end else begin
              // enabling thr empty with an empty queue raises it at once
              if (in_q.wdata[IER_THRE_BIT] && !int_enable_q[IER_THRE_BIT] &&
                  tx_count_q == '0) begin
                thre_pending_d = 1'b1;
              end
              int_enable_d = in_q.wdata[3:0];
            end
          end
          REG_ISR_FCR: begin
            fifo_on_d = in_q.wdata[FCR_EN_BIT];
            if ((in_q.wdata[FCR_EN_BIT] != fifo_on_q) || in_q.wdata[FCR_RXCLR_BIT]) begin
              rx_head_d  = '0;
              rx_count_d = '0;
            end
            if ((in_q.wdata[FCR_EN_BIT] != fifo_on_q) || in_q.wdata[FCR_TXCLR_BIT]) begin
              if (tx_count_q != '0) begin
                thre_pending_d = 1'b1;
              end
              tx_head_d  = '0;
              tx_count_d = '0;
            end
          end
          REG_LCR: begin
            line_control_d = in_q.wdata;
          end
          default: begin
          end
        endcase
      end

      FUNC_LINE_RX: begin
        if (rx_count_q < capacity) begin
          rx_we      = 1'b1;
          rx_count_d = rx_count_q + cnt_t'(1);
        end else begin
          overrun_flag_d = 1'b1;
        end
      end

      FUNC_TX_SLOT: begin
        if (tx_count_q != '0) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = tx_queue_q[tx_head_q];
          tx_head_d    = ptr_add(tx_head_q, cnt_t'(1));
          tx_count_d   = tx_count_q - cnt_t'(1);
          if (tx_count_q == cnt_t'(1)) begin
            thre_pending_d = 1'b1;
          end
        end
      end

      default: begin
      end
    endcase

    // status reflects the state after this word
    res.irq          = (int_enable_d[IER_RX_BIT] && rx_count_d != '0) ||
                       (int_enable_d[IER_THRE_BIT] && thre_pending_d);
    res.baud_divisor = {divisor_high_d, divisor_low_d};
    res.word_length  = line_control_d[1:0];
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // state registers, updated only when the word moves to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q      <= '0;
      rx_count_q     <= '0;
      tx_head_q      <= '0;
      tx_count_q     <= '0;
      int_enable_q   <= '0;
      line_control_q <= '0;
      divisor_low_q  <= '0;
      divisor_high_q <= '0;
      fifo_on_q      <= 1'b0;
      thre_pending_q <= 1'b0;
      overrun_flag_q <= 1'b0;
    end else if (advance) begin
      rx_head_q      <= rx_head_d;
      rx_count_q     <= rx_count_d;
      tx_head_q      <= tx_head_d;
      tx_count_q     <= tx_count_d;
      int_enable_q   <= int_enable_d;
      line_control_q <= line_control_d;
      divisor_low_q  <= divisor_low_d;
      divisor_high_q <= divisor_high_d;
      fifo_on_q      <= fifo_on_d;
      thre_pending_q <= thre_pending_d;
      overrun_flag_q <= overrun_flag_d;
    end
  end

  // queue storage writes
  always_ff @(posedge clk_i) begin
    if (advance && rx_we) begin
      rx_queue_q[rx_widx] <= in_q.line_byte;
    end
    if (advance && tx_we) begin
      tx_queue_q[tx_widx] <= in_q.wdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_rx_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_count_q <= cnt_t'(FIFO_DEPTH)) && (tx_count_q <= cnt_t'(FIFO_DEPTH)))
    else $error("queue count beyond depth");

  a_fifo_off_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_on_q |-> (rx_count_q <= cnt_t'(1)) && (tx_count_q <= cnt_t'(1)))
    else $error("queue holds more than one byte with fifos off");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word did not reach the output register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while the pipeline could move");

endmodule

`default_nettype wire

@@ dv/uart_16550_register_block_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_block_checker: result checker for the 16550 register block
// Watches both channels, runs its own copy of the register file and data
// queues on every accepted event word, and compares each result word with
// the oldest prediction.
// ----------------------------------------------------------------------------

module uart_16550_register_block_checker
  import uart16550_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  uart_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  uart_out_t out_data_i,
  output int        mismatch_count_o,
  output int        results_pending_o
);

  // shadow register file
  logic [7:0]  rx_mem [FIFO_DEPTH];
  logic [7:0]  tx_mem [FIFO_DEPTH];
  int unsigned rx_head, rx_count;
  int unsigned tx_head, tx_count;
  logic [3:0]  ier;
  logic [7:0]  lcr;
  logic [7:0]  div_lo, div_hi;
  logic        fifo_on;
  logic        thre_pending;
  logic        overrun;

  uart_out_t   predicted;
  uart_out_t   oldest;
  uart_out_t   expected_results [$];
  int          mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic reset_registers();
    rx_head      = 0;
    rx_count     = 0;
    tx_head      = 0;
    tx_count     = 0;
    ier          = '0;
    lcr          = '0;
    div_lo       = '0;
    div_hi       = '0;
    fifo_on      = 1'b0;
    thre_pending = 1'b0;
    overrun      = 1'b0;
  endtask

  task automatic flush_rx();
    rx_head  = 0;
    rx_count = 0;
  endtask

  // emptying a non-empty transmit queue raises thr-empty
  task automatic flush_tx();
    if (tx_count != 0) thre_pending = 1'b1;
    tx_head  = 0;
    tx_count = 0;
  endtask

  // one event through the register file, giving its result word
  task automatic uart_update(input uart_in_t w, output uart_out_t r);
    logic        dlab;
    logic [3:0]  new_ier;
    int unsigned room;
    r       = '0;
    dlab    = lcr[LCR_DLAB_BIT];
    room    = fifo_on ? FIFO_DEPTH : 1;
    new_ier = w.wdata[3:0];
    case (w.func)
      FUNC_READ: begin
        case (w.addr)
          REG_RHR_THR: begin
            if (dlab) begin
              r.rdata = div_lo;
            end else if (rx_count != 0) begin
              r.rdata  = rx_mem[rx_head];
              rx_head  = (rx_head + 1) % FIFO_DEPTH;
              rx_count = rx_count - 1;
            end
          end
          REG_IER: r.rdata = dlab ? div_hi : {4'b0000, ier};
          REG_ISR_FCR: begin
            r.rdata = fifo_on ? ISR_FIFO_ON : 8'h00;
            if (ier[IER_RX_BIT] && rx_count != 0) begin
              r.rdata |= ISR_RX_DATA;
            end else if (ier[IER_THRE_BIT] && thre_pending) begin
              r.rdata |= ISR_THRE;
              thre_pending = 1'b0;
            end else begin
              r.rdata |= ISR_NONE;
            end
          end
          REG_LCR: r.rdata = lcr;
          REG_LSR: begin
            r.rdata[LSR_DR_BIT]   = (rx_count != 0);
            r.rdata[LSR_OE_BIT]   = overrun;
            r.rdata[LSR_THRE_BIT] = (tx_count == 0);
            r.rdata[LSR_TEMT_BIT] = (tx_count == 0);
            overrun = 1'b0;
          end
          default: ;
        endcase
      end
      FUNC_WRITE: begin
        case (w.addr)
          REG_RHR_THR: begin
            if (dlab) begin
              div_lo = w.wdata;
            end else begin
              thre_pending = 1'b0;
              if (tx_count < room) begin
                tx_mem[(tx_head + tx_count) % FIFO_DEPTH] = w.wdata;
                tx_count = tx_count + 1;
              end
            end
          end
          REG_IER: begin
            if (dlab) begin
              div_hi = w.wdata;
            end else begin
              if (new_ier[IER_THRE_BIT] && !ier[IER_THRE_BIT] && tx_count == 0)
                thre_pending = 1'b1;
              ier = new_ier;
            end
          end
          REG_ISR_FCR: begin
            if (w.wdata[FCR_EN_BIT] != fifo_on) begin
              flush_rx();
              flush_tx();
            end
            fifo_on = w.wdata[FCR_EN_BIT];
            if (w.wdata[FCR_RXCLR_BIT]) flush_rx();
            if (w.wdata[FCR_TXCLR_BIT]) flush_tx();
          end
          REG_LCR: lcr = w.wdata;
          default: ;
        endcase
      end
      FUNC_LINE_RX: begin
        if (rx_count < room) begin
          rx_mem[(rx_head + rx_count) % FIFO_DEPTH] = w.line_byte;
          rx_count = rx_count + 1;
        end else begin
          overrun = 1'b1;
        end
      end
      default: begin
        if (tx_count != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_mem[tx_head];
          tx_head    = (tx_head + 1) % FIFO_DEPTH;
          tx_count   = tx_count - 1;
          if (tx_count == 0) thre_pending = 1'b1;
        end
      end
    endcase
    r.irq = (ier[IER_RX_BIT] && rx_count != 0) || (ier[IER_THRE_BIT] && thre_pending);
    r.baud_divisor = {div_hi, div_lo};
    r.word_length  = lcr[1:0];
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_registers();
      expected_results.delete();
      results_pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        uart_update(in_data_i, predicted);
        expected_results.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("rdata", oldest.rdata, out_data_i.rdata);
          check_field("tx_valid", oldest.tx_valid, out_data_i.tx_valid);
          check_field("tx_byte", oldest.tx_byte, out_data_i.tx_byte);
          check_field("irq", oldest.irq, out_data_i.irq);
          check_field("baud_divisor", oldest.baud_divisor, out_data_i.baud_divisor);
          check_field("word_length", oldest.word_length, out_data_i.word_length);
        end
      end
      results_pending_o <= expected_results.size();
    end
  end

endmodule

@@ dv/uart_16550_register_block_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_block_test: top of the 16550 register block testbench
// Drives event words into the block, stalls the result side at random, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module uart_16550_register_block_test
  import uart16550_pkg::*;
();

  localparam int RANDOM_WORDS = 650;
  // cycles with no handshake on either channel before giving up
  localparam int STALL_LIMIT  = 2000;
  // drain time after the last prediction is met
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  uart_in_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  uart_out_t out_data;

  // set during the stretch where neither side idles
  logic      calm;
  int        mismatch_count;
  int        results_pending;
  int        stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  uart_16550_register_block i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  uart_16550_register_block_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending)
  );

  // result side: stall with a chance of about 29 in a hundred unless in the calm stretch
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // build an event word; fields the event does not use get random bits
  function automatic uart_in_t make_word(logic [1:0] f, logic [2:0] a, logic [7:0] d);
    uart_in_t w;
    w.func      = f;
    w.addr      = (f == FUNC_READ || f == FUNC_WRITE) ? a : 3'($urandom);
    w.wdata     = (f == FUNC_WRITE) ? d : 8'($urandom);
    w.line_byte = (f == FUNC_LINE_RX) ? d : 8'($urandom);
    return w;
  endfunction

  // one random event, weighted toward data traffic so both queues see use
  function automatic uart_in_t random_word();
    int unsigned pick;
    logic [7:0]  d;
    pick = $urandom_range(99);
    d    = 8'($urandom);
    if (pick < 18) return make_word(FUNC_LINE_RX, REG_RHR_THR, d);
    if (pick < 32) return make_word(FUNC_TX_SLOT, REG_RHR_THR, d);
    if (pick < 46) return make_word(FUNC_WRITE, REG_RHR_THR, d);
    if (pick < 58) return make_word(FUNC_READ, REG_RHR_THR, d);
    if (pick < 66) return make_word(FUNC_READ, REG_LSR, d);
    if (pick < 74) return make_word(FUNC_READ, REG_ISR_FCR, d);
    if (pick < 80) return make_word(FUNC_READ, 3'($urandom), d);
    if (pick < 86) return make_word(FUNC_WRITE, REG_IER, d);
    // fcr: fifos mostly on, clear bits random
    if (pick < 91) return make_word(FUNC_WRITE, REG_ISR_FCR, {d[7:1], ($urandom_range(3) != 0)});
    // lcr: divisor latch access in about a quarter of writes
    if (pick < 96) return make_word(FUNC_WRITE, REG_LCR, {($urandom_range(3) == 0), d[6:0]});
    return make_word(FUNC_WRITE, 3'($urandom), d);
  endfunction

  // present one word, with a random gap first, and wait for its acceptance
  task automatic send_word(input uart_in_t w);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    int          sent;
    int unsigned burst_len;
    int unsigned burst_kind;
    uart_in_t    w;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset values, all offsets, divisor latch, queue limits
    send_word(make_word(FUNC_READ, REG_RHR_THR, 8'h00));   // empty receive queue reads zero
    send_word(make_word(FUNC_READ, REG_ISR_FCR, 8'h00));   // no interrupt pending
    send_word(make_word(FUNC_READ, REG_LSR, 8'h00));       // transmitter empty and idle
    send_word(make_word(FUNC_WRITE, REG_IER, 8'hFF));      // only low nibble kept, raises thr-empty
    send_word(make_word(FUNC_READ, REG_ISR_FCR, 8'h00));   // thr-empty reported and cleared
    send_word(make_word(FUNC_WRITE, REG_LCR, 8'h83));      // divisor latch access, eight bits
    send_word(make_word(FUNC_WRITE, REG_RHR_THR, 8'hFF));  // dll
    send_word(make_word(FUNC_WRITE, REG_IER, 8'hFF));      // dlm
    send_word(make_word(FUNC_READ, REG_RHR_THR, 8'h00));
    send_word(make_word(FUNC_READ, REG_IER, 8'h00));
    send_word(make_word(FUNC_WRITE, REG_LCR, 8'h03));
    send_word(make_word(FUNC_TX_SLOT, REG_RHR_THR, 8'h00)); // slot with nothing to send
    send_word(make_word(FUNC_WRITE, REG_RHR_THR, 8'hA5));
    send_word(make_word(FUNC_WRITE, REG_RHR_THR, 8'h5A));  // single-byte queue full, dropped
    send_word(make_word(FUNC_LINE_RX, REG_RHR_THR, 8'hFF));
    send_word(make_word(FUNC_LINE_RX, REG_RHR_THR, 8'h00)); // receive queue full, overrun
    send_word(make_word(FUNC_READ, REG_LSR, 8'h00));       // data ready and overrun, then overrun cleared
    send_word(make_word(FUNC_READ, REG_RHR_THR, 8'h00));
    send_word(make_word(FUNC_TX_SLOT, REG_RHR_THR, 8'h00)); // last byte out, thr-empty again
    send_word(make_word(FUNC_WRITE, REG_ISR_FCR, 8'h07));  // fifos on, both queues cleared
    send_word(make_word(FUNC_WRITE, REG_MCR, 8'hFF));      // mcr write ignored
    send_word(make_word(FUNC_READ, REG_MSR, 8'h00));       // msr reads zero
    send_word(make_word(FUNC_READ, REG_SCR, 8'h00));       // scr reads zero
    send_word(make_word(FUNC_WRITE, REG_ISR_FCR, 8'h00));  // fifos off, change clears queues
    send_word(make_word(FUNC_WRITE, REG_LCR, 8'h00));

    // random: single events mixed with bursts that fill and drain the queues
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm <= (sent >= 250 && sent < 400);
      if ($urandom_range(99) < 25) begin
        burst_len  = $urandom_range(20, 1);
        burst_kind = $urandom_range(3);
        repeat (burst_len) begin
          case (burst_kind)
            0:       w = make_word(FUNC_LINE_RX, REG_RHR_THR, 8'($urandom));
            1:       w = make_word(FUNC_READ, REG_RHR_THR, 8'($urandom));
            2:       w = make_word(FUNC_WRITE, REG_RHR_THR, 8'($urandom));
            default: w = make_word(FUNC_TX_SLOT, REG_RHR_THR, 8'($urandom));
          endcase
          send_word(w);
          sent++;
        end
      end else begin
        send_word(random_word());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // let the checker see the last word, then wait for every result word
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
